// File: rtl/core/bia_pkg.sv
// Shared constants, register indexes and status codes of the bitmap identifier allocator.
package bia_pkg;

  localparam int MAP_WORDS = 128;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = MAP_AW + 5;
  localparam int CNT_W     = IDX_W + 1;
  localparam int WORD_W    = 32;

  localparam int ID_W      = 16;
  localparam int COUNT_W   = 13;
  localparam int CFG_W     = 16;

  localparam logic [ID_W-1:0]    BASE_RESET  = 16'd300;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  localparam logic REG_BASE_ID  = 1'b0;
  localparam logic REG_ID_COUNT = 1'b1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_ALLOCATED    = 2'd0;
  localparam logic [1:0] ST_NONE_FREE    = 2'd1;
  localparam logic [1:0] ST_RELEASED     = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

endpackage

// File: rtl/core/bia_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bitmap_id_allocator.sv
// Top level of the bitmap identifier allocator: sequencer, range logic and bitmap memory.
//
// One used bit per identifier lives in a MAP_WORDS x 32 bitmap RAM. An allocate scans the
// RAM one word per cycle through its single read port and takes the lowest free bit; the
// scan ends at the first word with a free bit in range, or after the last word in range
// when none is free. A release reads and rewrites one word; an out-of-range release or an
// allocate on an empty range answers without leaving idle. Each result appears for exactly
// one cycle with done high and must be taken then. busy drops in the cycle done shows, so
// the next start may coincide with a result. Per-word valid flops cleared by reset stand
// for a zeroed map; no clearing pass is needed.
module bitmap_id_allocator
  import bia_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [ID_W-1:0]  release_id,
  output logic             done,
  output logic [ID_W-1:0]  result_id,
  output logic [1:0]       status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;

  localparam logic [16:0] CAP = 17'(MAP_WORDS * WORD_W);

  logic [1:0]         state;
  logic [ID_W-1:0]    base_id;
  logic [COUNT_W-1:0] id_count;
  logic [CNT_W-1:0]   n;
  logic [MAP_AW:0]    w;
  logic               chk_v;
  logic [MAP_AW-1:0]  chk_w;
  logic [4:0]         rel_bit;
  logic [MAP_AW-1:0]  rel_word;
  logic [MAP_WORDS-1:0] row_valid;
  logic               row_v_q;

  // Active range at the start beat.
  logic [16:0]        room;
  logic [16:0]        n_full;
  logic [CNT_W-1:0]   n_start;
  logic [16:0]        diff;
  logic               in_range;

  // Memory ports.
  logic               ram_we;
  logic [MAP_AW-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [MAP_AW-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_q;
  logic [WORD_W-1:0]  word;

  // Scan datapath.
  logic               issue;
  logic [CNT_W-1:0]   left;
  logic [WORD_W-1:0]  free_bits;
  logic               found;
  logic [4:0]         found_bit;
  logic [IDX_W-1:0]   k;

  assign busy = (state != S_IDLE);

  always_comb begin
    room   = 17'h10000 - {1'b0, base_id};
    n_full = {4'b0, id_count};
    if (n_full > CAP) begin
      n_full = CAP;
    end
    if (n_full > room) begin
      n_full = room;
    end
    n_start  = n_full[CNT_W-1:0];
    diff     = {1'b0, release_id} - {1'b0, base_id};
    in_range = (release_id >= base_id) && (diff < {{(17-CNT_W){1'b0}}, n_start});
  end

  assign word  = row_v_q ? ram_q : '0;
  assign issue = (state == S_SCAN) && (w < (MAP_AW+1)'(MAP_WORDS)) &&
                 ({w, 5'b0} < n);
  assign left  = n - {1'b0, chk_w, 5'b0};

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      free_bits[i] = ~word[i] && (CNT_W'(i) < left);
    end
    found     = |free_bits;
    found_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found_bit = 5'(i);
      end
    end
    k = {chk_w, found_bit};
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = w[MAP_AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = chk_w;
    ram_wdata = word | (WORD_W'(1) << found_bit);
    if (state == S_IDLE) begin
      ram_re    = start && (action == ACT_RELEASE) && in_range;
      ram_raddr = diff[IDX_W-1:5];
    end else if (state == S_SCAN) begin
      ram_re = issue;
      ram_we = chk_v && found;
    end else if (state == S_REL) begin
      ram_we    = 1'b1;
      ram_waddr = rel_word;
      ram_wdata = word & ~(WORD_W'(1) << rel_bit);
    end
  end

  bia_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      chk_v     <= 1'b0;
      row_valid <= '0;
      base_id   <= BASE_RESET;
      id_count  <= COUNT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ID:  base_id  <= cfg_data[ID_W-1:0];
          REG_ID_COUNT: id_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          chk_v <= 1'b0;
          if (start) begin
            if (action == ACT_ALLOC) begin
              if (n_start == '0) begin
                done <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_range) begin
              state <= S_REL;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          chk_v <= issue;
          if (chk_v && (found || !issue)) begin
            state <= S_IDLE;
            chk_v <= 1'b0;
            done  <= 1'b1;
          end
        end
        S_REL: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      row_v_q <= row_valid[ram_raddr];
    end
    case (state)
      S_IDLE: begin
        w        <= '0;
        n        <= n_start;
        rel_bit  <= diff[4:0];
        rel_word <= diff[IDX_W-1:5];
        if (start) begin
          if (action == ACT_ALLOC) begin
            result_id <= '0;
            status    <= ST_NONE_FREE;
          end else begin
            result_id <= release_id;
            status    <= ST_OUT_OF_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          w <= w + 1'b1;
        end
        chk_w <= w[MAP_AW-1:0];
        if (chk_v && found) begin
          result_id <= base_id + {{(ID_W-IDX_W){1'b0}}, k};
          status    <= ST_ALLOCATED;
        end
      end
      S_REL: begin
        status <= ST_RELEASED;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/bia_checker.sv
// Port-level checker for the bitmap identifier allocator, bound to the top level.
module bia_checker
  import bia_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic [ID_W-1:0] result_id,
  input logic [1:0]      status
);

  // A result ends the work of its beat, so busy is already low.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done asserted while busy");

  // An accepted beat either answers at once or holds the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat produced neither busy nor done");

  // No result appears without a beat in flight or just accepted.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> ($past(busy) || $past(start)))
    else $error("result without an accepted beat");

  // An exhausted allocate always returns identifier zero.
  a_none_free_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NONE_FREE)) |-> (result_id == '0))
    else $error("none-free result carries a nonzero id");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result_id(result_id),
  .status   (status)
);

// File: tb/tb_top.sv
// Self-checking testbench for the bitmap identifier allocator with a built-in bitmap predictor.
module tb_top;
  import bia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_SPACE       = MAP_WORDS * WORD_W;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS   = 1780;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      st;
  } alloc_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_BASE_ID;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             start = 1'b0;
  logic             action = ACT_ALLOC;
  logic [ID_W-1:0]  release_id = '0;
  logic             busy;
  logic             done;
  logic [ID_W-1:0]  result_id;
  logic [1:0]       status;

  // Predictor state: one used flag per bit index, plus the two registers.
  bit                 id_used [ID_SPACE];
  logic [ID_W-1:0]    base_id_q;
  logic [COUNT_W-1:0] id_count_q;

  alloc_result_t pending_results[$];
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            no_idle = 1'b0;

  bitmap_id_allocator uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .release_id (release_id),
    .done       (done),
    .result_id  (result_id),
    .status     (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Number of usable identifiers under the current registers.
  function automatic int unsigned active_ids();
    int unsigned n;
    n = id_count_q;
    if (n > ID_SPACE) n = ID_SPACE;
    if (n > 65536 - int'(base_id_q)) n = 65536 - int'(base_id_q);
    return n;
  endfunction

  function automatic alloc_result_t predict_allocation(logic act, logic [ID_W-1:0] rid);
    alloc_result_t r;
    int unsigned   n;
    int unsigned   k;
    n = active_ids();
    if (act == ACT_ALLOC) begin
      r.id = '0;
      r.st = ST_NONE_FREE;
      for (int unsigned i = 0; i < n; i++) begin
        if (!id_used[i]) begin
          id_used[i] = 1'b1;
          r.id = ID_W'(int'(base_id_q) + i);
          r.st = ST_ALLOCATED;
          break;
        end
      end
    end else begin
      r.id = rid;
      if (rid >= base_id_q && int'(rid) - int'(base_id_q) < n) begin
        k = int'(rid) - int'(base_id_q);
        id_used[k] = 1'b0;
        r.st = ST_RELEASED;
      end else begin
        r.st = ST_OUT_OF_RANGE;
      end
    end
    return r;
  endfunction

  // Sends one request beat and records its expected result at acceptance.
  task automatic issue_request(input logic act, input logic [ID_W-1:0] rid);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    release_id <= rid;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_allocation(act, rid));
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BASE_ID) base_id_q = data;
    else id_count_q = data[COUNT_W-1:0];
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result id %0d status %0d", $time, result_id, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_id !== want.id) begin
          $display("%0t: result_id mismatch, expected %0d actual %0d",
                   $time, want.id, result_id);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.st, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reset registers: lowest ids, freeing, double release and both range edges.
  task automatic test_reset_config();
    issue_request(ACT_ALLOC, 16'hFFFF);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_ALLOC, 16'h5A5A);
    issue_request(ACT_RELEASE, 16'd301);
    issue_request(ACT_RELEASE, 16'd301);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_RELEASE, 16'd299);
    issue_request(ACT_RELEASE, 16'd4396);
    issue_request(ACT_RELEASE, 16'd4395);
    issue_request(ACT_RELEASE, 16'hFFFF);
  endtask

  // Single usable id, then an empty range.
  task automatic test_exhaustion();
    wait_quiet();
    write_reg(REG_BASE_ID, 16'd0);
    write_reg(REG_ID_COUNT, 16'd1);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_RELEASE, 16'd0);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_ALLOC, 16'h0000);
    wait_quiet();
    write_reg(REG_ID_COUNT, 16'd0);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_RELEASE, 16'd0);
  endtask

  // Base at the top of the id space: only one id fits below 65536.
  task automatic test_top_edge();
    wait_quiet();
    write_reg(REG_BASE_ID, 16'hFFFF);
    write_reg(REG_ID_COUNT, 16'hFFFF);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_RELEASE, 16'hFFFF);
    issue_request(ACT_RELEASE, 16'hFFFE);
    issue_request(ACT_ALLOC, 16'h0000);
    issue_request(ACT_ALLOC, 16'h0000);
  endtask

  task automatic test_random_mix();
    int unsigned        beats;
    int unsigned        phase_len;
    int unsigned        kind;
    int unsigned        pick;
    int unsigned        alloc_pct;
    int unsigned        n;
    logic [ID_W-1:0]    rid;
    logic [CFG_W-1:0]   base_sel;
    logic [CFG_W-1:0]   cnt_sel;
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      wait_quiet();
      kind = $urandom_range(0, 2);
      pick = $urandom_range(0, 9);
      if (pick < 5) base_sel = CFG_W'($urandom_range(0, 1000));
      else if (pick < 7) base_sel = CFG_W'(65536 - $urandom_range(1, 120));
      else if (pick == 7) base_sel = 16'hFFFF;
      else base_sel = CFG_W'($urandom);
      case (kind)
        0: begin
          cnt_sel   = CFG_W'($urandom_range(1, 80));
          alloc_pct = 65;
        end
        1: begin
          cnt_sel   = CFG_W'($urandom_range(80, 700));
          alloc_pct = 85;
        end
        default: begin
          pick      = $urandom_range(0, 5);
          cnt_sel   = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd4096 : CFG_W'($urandom);
          alloc_pct = 55;
        end
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_BASE_ID, base_sel);
      if ($urandom_range(0, 3) != 0) write_reg(REG_ID_COUNT, cnt_sel);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        n = active_ids();
        if ($urandom_range(1, 100) <= alloc_pct) begin
          // The release id is a don't-care on an allocate; keep it toggling.
          issue_request(ACT_ALLOC, ID_W'($urandom));
        end else begin
          pick = $urandom_range(0, 19);
          if (pick < 15 && n > 0) rid = ID_W'(int'(base_id_q) + $urandom_range(0, n + 1));
          else if (pick < 17) rid = base_id_q - 1'b1;
          else rid = ID_W'($urandom);
          issue_request(ACT_RELEASE, rid);
        end
      end
      beats += phase_len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ID_SPACE; i++) id_used[i] = 1'b0;
    base_id_q  = BASE_RESET;
    id_count_q = COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_exhaustion();
    test_top_edge();
    test_random_mix();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bia_pkg.sv
rtl/core/bia_ram.sv
rtl/core/bitmap_id_allocator.sv
rtl/core/bia_checker.sv
tb/tb_top.sv
